FILE: rtl/gbkn_pkg.sv
// Shared types and constants of the GBK text normalizer.
// No dependencies; the normalizing core, the top level and the testbench import this package.
package gbkn_pkg;

	localparam int MAX_RES   = 3;   // results one item can cause
	localparam int CNT_W     = 2;   // holds 0..MAX_RES
	localparam int OUT_POS_W = 16;  // width of the reported position

	// GBK codes and the ASCII characters handled by the normalizer
	localparam logic [7:0] LEAD_FOLD   = 8'hA3;  // full-width ASCII block
	localparam logic [7:0] LEAD_SYM    = 8'hA1;  // symbol block lead
	localparam logic [7:0] TRAIL_SPACE = 8'hA1;  // ideographic space trail
	localparam logic [7:0] FOLD_OFFSET = 8'h80;  // trail to half-width offset
	localparam logic [7:0] LONE_FOLD   = 8'h80;  // lone final full-width lead
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0A;
	localparam logic [7:0] CH_CR       = 8'h0D;
	localparam logic [7:0] CH_SPACE    = 8'h20;

	// one result item
	typedef struct packed {
		logic [7:0]           out_byte;
		logic [OUT_POS_W-1:0] out_pos;
		logic                 has_byte;
		logic                 out_last;
	} res_t;

	typedef res_t [MAX_RES-1:0] res_vec_t;

endpackage

FILE: rtl/gbkn_if.sv
// Valid/ready channel interfaces of the GBK text normalizer.
// Depends on nothing; one interface carries source bytes, one results.
interface gbkn_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  in_byte;
	logic [15:0] in_pos;
	logic        in_last;

	modport source (output valid, in_byte, in_pos, in_last, input ready);
	modport sink   (input valid, in_byte, in_pos, in_last, output ready);
endinterface

interface gbkn_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [15:0] out_pos;
	logic        has_byte;
	logic        out_last;

	modport source (output valid, out_byte, out_pos, has_byte, out_last, input ready);
	modport sink   (input valid, out_byte, out_pos, has_byte, out_last, output ready);
endinterface

FILE: rtl/gbkn_fold.sv
// Normalizing core: folds full-width GBK pairs, maps whitespace, collapses
// space runs, and holds the lead byte and pending space between items.
// Depends on gbkn_pkg.
module gbkn_fold #(
	parameter int POS_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [7:0]                in_byte,
	input  logic [15:0]               in_pos,
	input  logic                      in_last,
	input  logic                      take,
	output gbkn_pkg::res_vec_t        res,
	output logic [gbkn_pkg::CNT_W-1:0] res_cnt
);
	import gbkn_pkg::*;

	// state carried from item to item
	logic [7:0]          lead_byte_q;
	logic [POS_BITS-1:0] lead_pos_q;
	logic                lead_held_q;
	logic                space_held_q;
	logic [POS_BITS-1:0] space_pos_q;
	logic                prev_space_q;

	logic [31:0]         pin_w;
	logic [POS_BITS-1:0] pin;

	// stage-one output: up to two bytes
	logic                v0, v1;
	logic [7:0]          sb0, sb1;
	logic [POS_BITS-1:0] sp0, sp1;
	logic                nxt_lead_held;

	// stage two/three working values
	logic [1:0]          vv;
	logic [7:0]          sbb [2];
	logic [POS_BITS-1:0] spp [2];
	logic [7:0]          bc;
	logic                sh, ps;
	logic [POS_BITS-1:0] shp;
	logic [CNT_W-1:0]    n;

	function automatic res_t mk(input logic [7:0] b, input logic [POS_BITS-1:0] p);
		logic [31:0] w;
		res_t r;
		w = 32'(p);
		r.out_byte = b;
		r.out_pos  = w[OUT_POS_W-1:0];
		r.has_byte = 1'b1;
		r.out_last = 1'b0;
		return r;
	endfunction

	// keep positions at POS_BITS
	assign pin_w = 32'(in_pos);
	assign pin   = pin_w[POS_BITS-1:0];

	// stage one: pair folding
	always_comb begin
		v0 = 1'b0;
		v1 = 1'b0;
		sb0 = in_byte;
		sb1 = in_byte;
		sp0 = pin;
		sp1 = pin;
		nxt_lead_held = 1'b0;
		if (lead_held_q) begin
			sp0 = lead_pos_q;
			v0  = 1'b1;
			if (lead_byte_q == LEAD_FOLD) begin
				sb0 = in_byte + FOLD_OFFSET;
			end else if (lead_byte_q == LEAD_SYM && in_byte == TRAIL_SPACE) begin
				sb0 = CH_SPACE;
			end else begin
				sb0 = lead_byte_q;
				v1  = 1'b1;
			end
		end else if (!in_byte[7]) begin
			v0 = 1'b1;
		end else if (in_last) begin
			v0  = 1'b1;
			sb0 = (in_byte == LEAD_FOLD) ? LONE_FOLD : in_byte;
		end else begin
			nxt_lead_held = 1'b1;
		end
	end

	assign vv     = {v1, v0};
	assign sbb[0] = sb0;
	assign sbb[1] = sb1;
	assign spp[0] = sp0;
	assign spp[1] = sp1;

	// stages two and three: whitespace mapping and run collapsing
	always_comb begin
		sh  = space_held_q;
		shp = space_pos_q;
		ps  = prev_space_q;
		n   = '0;
		res = '0;
		bc  = '0;
		for (int k = 0; k < 2; k++) begin
			if (vv[k]) begin
				bc = sbb[k];
				if (bc == CH_TAB || bc == CH_CR || bc == CH_LF) begin
					bc = CH_SPACE;
				end
				if (bc == CH_SPACE) begin
					if (sh) begin
						res[n] = mk(CH_SPACE, shp);
						n  = n + 1'b1;
						sh = 1'b0;
						ps = 1'b1;
					end else if (!ps) begin
						sh  = 1'b1;
						shp = spp[k];
					end
				end else begin
					if (sh) begin
						res[n] = mk(CH_SPACE, shp);
						n  = n + 1'b1;
						sh = 1'b0;
					end
					res[n] = mk(bc, spp[k]);
					n  = n + 1'b1;
					ps = 1'b0;
				end
			end
		end
		// mark the end of the string; a pending single space is dropped
		if (in_last) begin
			if (n == '0) begin
				res[0] = '0;
				res[0].out_last = 1'b1;
				n = CNT_W'(1);
			end else begin
				res[n - 1'b1].out_last = 1'b1;
			end
		end
	end

	assign res_cnt = n;

	// advance state when the item is taken; clear it at the end of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_byte_q  <= '0;
			lead_pos_q   <= '0;
			lead_held_q  <= 1'b0;
			space_held_q <= 1'b0;
			space_pos_q  <= '0;
			prev_space_q <= 1'b0;
		end else if (take) begin
			if (in_last) begin
				lead_byte_q  <= '0;
				lead_pos_q   <= '0;
				lead_held_q  <= 1'b0;
				space_held_q <= 1'b0;
				space_pos_q  <= '0;
				prev_space_q <= 1'b0;
			end else begin
				lead_held_q  <= nxt_lead_held;
				if (nxt_lead_held) begin
					lead_byte_q <= in_byte;
					lead_pos_q  <= pin;
				end
				space_held_q <= sh;
				space_pos_q  <= shp;
				prev_space_q <= ps;
			end
		end
	end

endmodule

FILE: rtl/gbk_text_normalizer_unit.sv
// Top level of the GBK text normalizer: input register, normalizing core,
// result buffer. Depends on gbkn_pkg, gbkn_if and gbkn_fold.
//
// Takes one GBK byte per item and delivers normalized bytes with the
// position of their first source byte. Each byte waits in the input
// register, then is folded combinationally into a result buffer of up to
// three items, which drains one item per cycle while the output is ready.
// A new byte is accepted every cycle as long as each byte causes at most
// one result and the output is not stalled; a byte that causes two or
// three results holds the input while the result buffer drains. A lead
// byte or a pending space produces no result until the next byte. The
// last byte of a string always yields a result marked out_last, byte-less
// when nothing else is left to send; positions are kept in POS_BITS bits.
module gbk_text_normalizer_unit #(
	parameter int POS_BITS = 16
) (
	input logic        clk,
	input logic        arst_n,
	gbkn_in_if.sink    raw,
	gbkn_out_if.source norm
);
	import gbkn_pkg::*;

	// input register
	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic [15:0] pos_s1;
	logic        last_s1;

	// result buffer
	res_vec_t         slot_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] hd_q;

	res_vec_t         res;
	logic [CNT_W-1:0] res_cnt;
	logic             out_fire;
	logic             buf_free;
	logic             take;

	assign out_fire = norm.valid && norm.ready;
	assign buf_free = (cnt_q == '0) || (cnt_q == CNT_W'(1) && out_fire);
	assign take     = vld_s1 && buf_free;
	assign raw.ready = !vld_s1 || take;

	gbkn_fold #(
		.POS_BITS(POS_BITS)
	) u_fold (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_byte (byte_s1),
		.in_pos  (pos_s1),
		.in_last (last_s1),
		.take    (take),
		.res     (res),
		.res_cnt (res_cnt)
	);

	// load the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (raw.ready) begin
			vld_s1 <= raw.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (raw.valid && raw.ready) begin
			byte_s1 <= raw.in_byte;
			pos_s1  <= raw.in_pos;
			last_s1 <= raw.in_last;
		end
	end

	// fill the result buffer or advance through it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hd_q  <= '0;
		end else if (take) begin
			cnt_q <= res_cnt;
			hd_q  <= '0;
		end else if (out_fire) begin
			cnt_q <= cnt_q - 1'b1;
			hd_q  <= hd_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			slot_q <= res;
		end
	end

	// present the head of the buffer
	assign norm.valid    = (cnt_q != '0);
	assign norm.out_byte = slot_q[hd_q].out_byte;
	assign norm.out_pos  = slot_q[hd_q].out_pos;
	assign norm.has_byte = slot_q[hd_q].has_byte;
	assign norm.out_last = slot_q[hd_q].out_last;

endmodule

FILE: rtl/gbkn_checker.sv
// Port-level checks of the GBK text normalizer, bound to its top level.
// Depends on gbk_text_normalizer_unit and its channel interfaces.
module gbkn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        raw_ready,
	input logic        norm_valid,
	input logic        norm_ready,
	input logic [7:0]  norm_out_byte,
	input logic [15:0] norm_out_pos,
	input logic        norm_has_byte,
	input logic        norm_out_last
);

	// hold a stalled result
	a_norm_hold: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && !norm_ready |=> norm_valid && $stable(norm_out_byte)
			&& $stable(norm_out_pos) && $stable(norm_has_byte) && $stable(norm_out_last))
		else $error("stalled result item changed");

	// a byte-less result only ends a string and carries zeros
	a_empty_marker: assert property (@(posedge clk) disable iff (!arst_n)
		norm_valid && !norm_has_byte |-> norm_out_last && norm_out_byte == 8'h00
			&& norm_out_pos == 16'h0000)
		else $error("byte-less result is not a clean end marker");

	// an empty result buffer never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!norm_valid |-> raw_ready)
		else $error("input stalled with no pending result");

	// nothing is offered once a reset edge has cleared the buffer
	a_quiet_in_reset: assert property (@(posedge clk)
		!arst_n |=> !norm_valid)
		else $error("result offered during reset");

endmodule

bind gbk_text_normalizer_unit gbkn_checker u_gbkn_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.raw_ready     (raw.ready),
	.norm_valid    (norm.valid),
	.norm_ready    (norm.ready),
	.norm_out_byte (norm.out_byte),
	.norm_out_pos  (norm.out_pos),
	.norm_has_byte (norm.has_byte),
	.norm_out_last (norm.out_last)
);

FILE: test/gbk_text_normalizer_unit_tb.sv
// Self-checking testbench for gbk_text_normalizer_unit: GBK byte strings in,
// normalized bytes out, each result checked against an in-bench predictor.
// Depends on gbkn_pkg, gbkn_if and the RTL of gbk_text_normalizer_unit.
module gbk_text_normalizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gbkn_pkg::*;

	localparam int ITEM_TARGET  = 450;
	localparam int TAIL_ITEMS   = 60;   // final items sent with no idling
	localparam int HOLD_OFF_AT  = 150;  // items taken before the long sink stall
	localparam int HOLD_OFF_LEN = 60;
	localparam int QUIET_LIMIT  = 500;  // cycles with no handshake at all
	localparam int SETTLE       = 20;

	typedef struct packed {
		logic [7:0]  code;
		logic [15:0] pos;
		logic        last;
		logic        drain;  // wait until every result is out before sending
	} src_item_t;

	logic clk = 1'b0;
	logic arst_n;

	gbkn_in_if  raw_if ();
	gbkn_out_if norm_if ();

	gbk_text_normalizer_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.raw   (raw_if),
		.norm  (norm_if)
	);

	src_item_t pending_bytes[$];
	res_t      predicted_norm[$];

	int bytes_taken;     // nonblocking, so every block sees the pre-edge count
	int results_seen;    // nonblocking, same reason
	int predicted_total;
	int tail_start;
	int mismatches;
	int src_gap;
	int sink_gap;
	int hold_off_left;
	bit hold_off_done;
	int quiet_cycles;
	logic idle_ok;

	// predictor state
	logic [7:0]  lead_code;
	logic [15:0] lead_pos;
	bit          lead_waiting;
	bit          space_waiting;
	logic [15:0] space_pos;
	bit          last_was_space;
	int          step_count;

	assign idle_ok = (bytes_taken < tail_start) && (bytes_taken % 96 < 64);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void add_byte(logic [7:0] code, logic [15:0] pos, bit last, bit drain);
		src_item_t it;
		it.code  = code;
		it.pos   = pos;
		it.last  = last;
		it.drain = drain;
		pending_bytes.push_back(it);
	endfunction

	function automatic void push_norm(logic [7:0] code, logic [15:0] pos);
		res_t r;
		r.out_byte = code;
		r.out_pos  = pos;
		r.has_byte = 1'b1;
		r.out_last = 1'b0;
		predicted_norm.push_back(r);
		step_count++;
	endfunction

	// whitespace folding and space-run collapse
	function automatic void squeeze_space(logic [7:0] code, logic [15:0] pos);
		logic [7:0] c;
		c = code;
		if (c == CH_TAB || c == CH_CR || c == CH_LF)
			c = CH_SPACE;
		if (c == CH_SPACE) begin
			if (space_waiting) begin
				push_norm(CH_SPACE, space_pos);
				space_waiting  = 1'b0;
				last_was_space = 1'b1;
			end else if (!last_was_space) begin
				space_waiting = 1'b1;
				space_pos     = pos;
			end
		end else begin
			if (space_waiting) begin
				push_norm(CH_SPACE, space_pos);
				space_waiting = 1'b0;
			end
			push_norm(c, pos);
			last_was_space = 1'b0;
		end
	endfunction

	// expected results of one accepted source byte
	function automatic void predict_norm(logic [7:0] code, logic [15:0] pos, logic last);
		res_t r;
		step_count = 0;
		if (lead_waiting) begin
			lead_waiting = 1'b0;
			if (lead_code == LEAD_FOLD)
				squeeze_space(code + FOLD_OFFSET, lead_pos);
			else if (lead_code == LEAD_SYM && code == TRAIL_SPACE)
				squeeze_space(CH_SPACE, lead_pos);
			else begin
				squeeze_space(lead_code, lead_pos);
				squeeze_space(code, pos);
			end
		end else if (!code[7])
			squeeze_space(code, pos);
		else if (last)
			squeeze_space(code == LEAD_FOLD ? LONE_FOLD : code, pos);
		else begin
			lead_waiting = 1'b1;
			lead_code    = code;
			lead_pos     = pos;
		end
		// mark the end of the string, with a byte-less marker if nothing came out
		if (last) begin
			if (step_count > 0) begin
				r = predicted_norm.pop_back();
				r.out_last = 1'b1;
				predicted_norm.push_back(r);
			end else begin
				r = '0;
				r.out_last = 1'b1;
				predicted_norm.push_back(r);
				step_count = 1;
			end
			lead_code      = '0;
			lead_pos       = '0;
			lead_waiting   = 1'b0;
			space_waiting  = 1'b0;
			space_pos      = '0;
			last_was_space = 1'b0;
		end
		predicted_total += step_count;
	endfunction

	// driver: offer pending items, predict each accepted one
	always @(posedge clk or negedge arst_n) begin
		src_item_t   nxt;
		logic        nv;
		logic [7:0]  nb;
		logic [15:0] np;
		logic        nl;
		if (!arst_n) begin
			raw_if.valid   <= 1'b0;
			raw_if.in_byte <= '0;
			raw_if.in_pos  <= '0;
			raw_if.in_last <= 1'b0;
			bytes_taken    <= 0;
			src_gap = 0;
		end else begin
			nv = raw_if.valid;
			nb = raw_if.in_byte;
			np = raw_if.in_pos;
			nl = raw_if.in_last;
			if (raw_if.valid && raw_if.ready) begin
				predict_norm(raw_if.in_byte, raw_if.in_pos, raw_if.in_last);
				bytes_taken <= bytes_taken + 1;
				nv = 1'b0;
				if (idle_ok && hold_off_left == 0 && $urandom_range(0, 4) == 0)
					src_gap = $urandom_range(1, 5);
			end
			if (!nv) begin
				if (src_gap != 0)
					src_gap--;
				else if (pending_bytes.size() != 0 && (!pending_bytes[0].drain ||
						predicted_total == results_seen + (norm_if.valid && norm_if.ready))) begin
					nxt = pending_bytes.pop_front();
					nv  = 1'b1;
					nb  = nxt.code;
					np  = nxt.pos;
					nl  = nxt.last;
				end
			end
			raw_if.valid   <= nv;
			raw_if.in_byte <= nb;
			raw_if.in_pos  <= np;
			raw_if.in_last <= nl;
		end
	end

	// long sink stall, started once the stream is well under way
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_off_left <= 0;
			hold_off_done <= 1'b0;
		end else if (!hold_off_done && bytes_taken >= HOLD_OFF_AT) begin
			hold_off_left <= HOLD_OFF_LEN;
			hold_off_done <= 1'b1;
		end else if (hold_off_left != 0)
			hold_off_left <= hold_off_left - 1;
	end

	// monitor: check each accepted result against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		logic nr;
		if (!arst_n) begin
			norm_if.ready <= 1'b0;
			results_seen  <= 0;
			sink_gap = 0;
		end else begin
			if (norm_if.valid && norm_if.ready) begin
				got.out_byte = norm_if.out_byte;
				got.out_pos  = norm_if.out_pos;
				got.has_byte = norm_if.has_byte;
				got.out_last = norm_if.out_last;
				results_seen <= results_seen + 1;
				if (predicted_norm.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected item: byte %02h pos %04h has %0d last %0d",
							got.out_byte, got.out_pos, got.has_byte, got.out_last);
				end else begin
					want = predicted_norm.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %02h/%04h/%0d/%0d got %02h/%04h/%0d/%0d",
								want.out_byte, want.out_pos, want.has_byte, want.out_last,
								got.out_byte, got.out_pos, got.has_byte, got.out_last);
					end
				end
			end
			// drop ready in the long stall and in random short bursts
			nr = 1'b1;
			if (hold_off_left != 0)
				nr = 1'b0;
			else if (sink_gap != 0) begin
				sink_gap--;
				nr = 1'b0;
			end else if (idle_ok && $urandom_range(0, 6) == 0) begin
				sink_gap = $urandom_range(0, 4);
				nr = 1'b0;
			end
			norm_if.ready <= nr;
		end
	end

	// watchdog: end the run when no item moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((raw_if.valid && raw_if.ready) || (norm_if.valid && norm_if.ready))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	// stimulus and end of run
	initial begin
		logic [7:0]  demo_code [25];
		bit          demo_last [25];
		logic [7:0]  text[$];
		logic [15:0] base;
		int          n_tok;
		int          run;
		bit          drain;

		raw_if.valid   = 1'b0;
		raw_if.in_byte = '0;
		raw_if.in_pos  = '0;
		raw_if.in_last = 1'b0;
		norm_if.ready  = 1'b0;
		arst_n         = 1'b0;
		quiet_cycles   = 0;
		mismatches     = 0;
		predicted_total = 0;
		lead_code      = '0;
		lead_pos       = '0;
		lead_waiting   = 1'b0;
		space_waiting  = 1'b0;
		space_pos      = '0;
		last_was_space = 1'b0;

		// directed strings: folds, ideographic space, whitespace run, raw pairs,
		// trail 0x80 giving a zero byte, dropped final space, lone final leads,
		// final run of two spaces, folded space and folded tab at the end
		demo_code = '{8'h01, LEAD_FOLD, 8'hC1, LEAD_SYM, TRAIL_SPACE, CH_TAB, CH_CR, CH_LF,
			8'h7F, 8'hB0, 8'hA1, LEAD_FOLD, 8'h80, LEAD_SYM, 8'h41, CH_SPACE,
			LEAD_FOLD, 8'hFF, CH_SPACE, CH_SPACE, LEAD_FOLD, 8'hA0, CH_SPACE,
			LEAD_FOLD, 8'h89};
		demo_last = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1,
			1, 1, 0, 1, 0, 0, 1, 0, 1};
		// positions wrap through the top and bottom of the range
		foreach (demo_code[k])
			add_byte(demo_code[k], 16'hFFF0 + k[15:0], demo_last[k], k == 16);

		// random part: mostly well-formed strings, some stray bytes
		while (pending_bytes.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0)
				add_byte(8'($urandom_range(1, 255)), 16'($urandom_range(0, 65535)),
					$urandom_range(0, 3) == 0, 1'b0);
			else begin
				text.delete();
				n_tok = $urandom_range(1, 8);
				for (int t = 0; t < n_tok; t++) begin
					case ($urandom_range(0, 9))
						0, 1, 2: text.push_back(8'($urandom_range(1, 127)));
						3: text.push_back(CH_SPACE);
						4: begin
							case ($urandom_range(0, 2))
								0: text.push_back(CH_TAB);
								1: text.push_back(CH_CR);
								default: text.push_back(CH_LF);
							endcase
						end
						5: begin
							text.push_back(LEAD_FOLD);
							text.push_back(8'($urandom_range(1, 255)));
						end
						6: begin
							text.push_back(LEAD_SYM);
							text.push_back(TRAIL_SPACE);
						end
						7: begin
							text.push_back(LEAD_SYM);
							text.push_back(8'($urandom_range(1, 255)));
						end
						8: begin
							text.push_back(8'($urandom_range(128, 255)));
							text.push_back(8'($urandom_range(1, 255)));
						end
						default: begin
							run = $urandom_range(2, 4);
							repeat (run) text.push_back(CH_SPACE);
						end
					endcase
				end
				// end some strings on a lone lead
				if ($urandom_range(0, 3) == 0)
					text.push_back($urandom_range(0, 1) ? LEAD_FOLD : 8'($urandom_range(128, 255)));
				base  = 16'($urandom_range(0, 65535));
				drain = $urandom_range(0, 29) == 0;
				foreach (text[k])
					add_byte(text[k], base + k[15:0], k == text.size() - 1, drain && k == 0);
			end
		end
		// close the stream so no lead or space stays held
		add_byte(8'($urandom_range(1, 127)), 16'($urandom_range(0, 65535)), 1'b1, 1'b0);
		tail_start = pending_bytes.size() - TAIL_ITEMS;

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (pending_bytes.size() != 0 || raw_if.valid)
			@(posedge clk);
		while (predicted_norm.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/gbkn_pkg.sv
rtl/gbkn_if.sv
rtl/gbkn_fold.sv
rtl/gbk_text_normalizer_unit.sv
rtl/gbkn_checker.sv
test/gbk_text_normalizer_unit_tb.sv
